// File: design/gdr_pkg.sv
// ---------------------------------------------------------------------------
// gdr_pkg
// Shared types and constants for the grid DDA wall ray caster.
// ---------------------------------------------------------------------------
package gdr_pkg;

    // divider widths: numerator / quotient and denominator
    localparam int NUM_W = 48;
    localparam int DEN_W = 32;
    // signed map coordinate during the walk (start cell plus up to 1023 steps)
    localparam int MW = 12;
    // signed ray component, Q16
    localparam int RW = 30;
    // side distance accumulators
    localparam int SW = 44;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd7;

    localparam logic CMD_CAST  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic       command;
        logic [9:0] column;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [2:0] cell_value;
    } gdr_in_t;

    typedef struct packed {
        logic [9:0]  column_out;
        logic        hit;
        logic        side;
        logic [4:0]  hit_x;
        logic [4:0]  hit_y;
        logic [2:0]  texture_index;
        logic [23:0] distance;
        logic [9:0]  stripe_start;
        logic [9:0]  stripe_end;
        logic [15:0] wall_u;
        logic [7:0]  brightness;
    } gdr_out_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } gdr_div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } gdr_div_rsp_t;

endpackage

// File: design/grid_dda_wall_raycast.sv
// Cast: the divider serves camera x, two deltas, distance and line height; each
//   map step reads the map RAM.
// One item is in work at a time; a finished result waits in
//   the output register while the next item is taken.
// Reset: registers go to their reset values, then a clearing pass zeroes all
//   MAP_SIZE*MAP_SIZE map cells; no item is taken meanwhile.
// ---------------------------------------------------------------------------
// grid_dda_wall_raycast
// Per-column DDA ray caster over a tile map held in a synchronous RAM.
// ---------------------------------------------------------------------------
module grid_dda_wall_raycast #(
    parameter int MAP_SIZE       = 32,
    parameter int MAX_STEPS      = 50,
    parameter int SHADE_DISTANCE = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gdr_pkg::gdr_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gdr_pkg::gdr_out_t                  m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int STW   = $clog2(MAX_STEPS + 1);
    localparam int MW    = gdr_pkg::MW;
    localparam int RW    = gdr_pkg::RW;
    localparam int SW    = gdr_pkg::SW;
    localparam int NW    = gdr_pkg::NUM_W;
    localparam int DW    = gdr_pkg::DEN_W;
    localparam int SFULL = SHADE_DISTANCE * 65536;
    // ceil(2^24 / SHADE_DISTANCE); exact floor division for shade numerators
    localparam longint BRI_M = ((longint'(1) << 24) + SHADE_DISTANCE - 1) / SHADE_DISTANCE;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_CAM   = 5'd2;
    localparam logic [4:0] S_CAMW  = 5'd3;
    localparam logic [4:0] S_MRX   = 5'd4;
    localparam logic [4:0] S_MRY   = 5'd5;
    localparam logic [4:0] S_RY    = 5'd6;
    localparam logic [4:0] S_DDX   = 5'd7;
    localparam logic [4:0] S_DDXW  = 5'd8;
    localparam logic [4:0] S_DDY   = 5'd9;
    localparam logic [4:0] S_DDYW  = 5'd10;
    localparam logic [4:0] S_SDX   = 5'd11;
    localparam logic [4:0] S_SDY   = 5'd12;
    localparam logic [4:0] S_SDYW  = 5'd13;
    localparam logic [4:0] S_STEP  = 5'd14;
    localparam logic [4:0] S_LOOK  = 5'd15;
    localparam logic [4:0] S_DIST  = 5'd16;
    localparam logic [4:0] S_DISTW = 5'd17;
    localparam logic [4:0] S_WALL  = 5'd18;
    localparam logic [4:0] S_WALLW = 5'd19;
    localparam logic [4:0] S_LH    = 5'd20;
    localparam logic [4:0] S_LHW   = 5'd21;
    localparam logic [4:0] S_BRI   = 5'd22;
    localparam logic [4:0] S_BRIW  = 5'd23;
    localparam logic [4:0] S_DONE  = 5'd24;

    // configuration
    logic [20:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [9:0]         width_reg, height_reg;

    // sequencer and working state
    logic [4:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [9:0]          column_reg;
    logic [26:0]         cam_mag_reg;
    logic                cam_neg_reg;
    logic signed [RW-1:0] rx_reg, ry_reg;
    logic [32:0]         ddx_reg, ddy_reg;
    logic [SW-1:0]       sdx_reg, sdy_reg;
    logic signed [MW-1:0] mx_reg, my_reg;
    logic                side_reg, hit_reg, inb_reg;
    logic [STW-1:0]      steps_reg;
    logic [2:0]          tile_reg;
    logic [23:0]         dist_reg;
    logic [25:0]         lh_reg;
    logic [15:0]         wall_u_reg;
    logic [7:0]          bright_reg;
    logic [56:0]         mul_p_reg;

    logic                m_valid_reg;
    gdr_pkg::gdr_out_t   m_data_reg;

    // map RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [2:0]    ram_wdata, ram_rdata;

    gdr_pkg::gdr_div_req_t div_req;
    gdr_pkg::gdr_div_rsp_t div_rsp;

    gdr_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gdr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- derived values ----------------
    logic [9:0]           w_eff, h_eff;
    logic signed [11:0]   cnum;
    logic [10:0]          cnum_mag;
    logic [17:0]          plane_x_mag, plane_y_mag;
    logic [RW-1:0]        rx_mag, ry_mag;
    logic                 rx_nz, ry_nz, rx_neg, ry_neg;
    logic [16:0]          gap_x, gap_y;
    logic signed [RW-1:0] prod_term;
    logic signed [RW-1:0] dir_ext;
    logic                 step_x;
    logic signed [MW-1:0] nmx, nmy;
    logic                 n_inb;
    logic                 w_accept, wr_inb;
    logic signed [MW:0]   mp;
    logic signed [MW+16:0] numv;
    logic [MW+16:0]       numv_mag;
    logic signed [RW-1:0] dden;
    logic [RW-1:0]        dden_mag;
    logic [15:0]          wall_q, wall_p;
    logic                 wall_neg;
    logic [31:0]          dm, shade_x;
    logic [23:0]          mul_a;
    logic [32:0]          mul_b;
    logic [8:0]           half_h;
    logic [24:0]          half_lh;
    logic signed [26:0]   start_s;
    logic [26:0]          end_s;
    logic [9:0]           start_c, end_c;
    logic                 out_load;

    assign w_eff = (width_reg == 10'd0) ? 10'd1 : width_reg;
    assign h_eff = (height_reg == 10'd0) ? 10'd1 : height_reg;

    assign cnum     = $signed({1'b0, column_reg, 1'b0}) - $signed({2'b00, w_eff});
    assign cnum_mag = cnum[11] ? 11'(-cnum) : cnum[10:0];

    assign plane_x_mag = plane_x_reg[17] ? 18'(-plane_x_reg) : 18'(plane_x_reg);
    assign plane_y_mag = plane_y_reg[17] ? 18'(-plane_y_reg) : 18'(plane_y_reg);

    assign rx_neg = rx_reg[RW-1];
    assign ry_neg = ry_reg[RW-1];
    assign rx_nz  = (rx_reg != '0);
    assign ry_nz  = (ry_reg != '0);
    assign rx_mag = rx_neg ? RW'(-rx_reg) : RW'(rx_reg);
    assign ry_mag = ry_neg ? RW'(-ry_reg) : RW'(ry_reg);

    assign gap_x = rx_neg ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
    assign gap_y = ry_neg ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};

    // plane * cam term, sign applied to the truncated magnitude
    always_comb begin
        if (state_reg == S_MRY) begin
            dir_ext   = RW'(dir_x_reg);
            prod_term = (plane_x_reg[17] ^ cam_neg_reg) ? -$signed(mul_p_reg[16 +: RW])
                                                        : $signed(mul_p_reg[16 +: RW]);
        end else begin
            dir_ext   = RW'(dir_y_reg);
            prod_term = (plane_y_reg[17] ^ cam_neg_reg) ? -$signed(mul_p_reg[16 +: RW])
                                                        : $signed(mul_p_reg[16 +: RW]);
        end
    end

    // DDA axis choice; a zero x component never steps x
    assign step_x = rx_nz && (!ry_nz || (sdx_reg < sdy_reg));
    assign nmx = step_x ? (rx_neg ? mx_reg - MW'(1) : mx_reg + MW'(1)) : mx_reg;
    assign nmy = step_x ? my_reg : (ry_neg ? my_reg - MW'(1) : my_reg + MW'(1));
    assign n_inb = !nmx[MW-1] && ($unsigned(nmx) < MW'(MAP_SIZE))
                && !nmy[MW-1] && ($unsigned(nmy) < MW'(MAP_SIZE));
    assign ram_raddr = AW'($unsigned(nmx)) * AW'(MAP_SIZE) + AW'($unsigned(nmy));

    assign w_accept = s_valid && s_ready && (s_data.command == gdr_pkg::CMD_WRITE);
    assign wr_inb   = (32'(s_data.cell_x) < MAP_SIZE) && (32'(s_data.cell_y) < MAP_SIZE);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = 3'd0;
        if (state_reg == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (w_accept && wr_inb) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(s_data.cell_x) * AW'(MAP_SIZE) + AW'(s_data.cell_y);
            ram_wdata = s_data.cell_value;
        end
    end

    // boundary distance numerator on the crossed axis
    always_comb begin
        if (side_reg) begin
            mp   = {my_reg[MW-1], my_reg} + (MW+1)'(ry_neg);
            numv = {mp, 16'h0000} - $signed({{(MW-5){1'b0}}, pos_y_reg});
            dden = ry_reg;
        end else begin
            mp   = {mx_reg[MW-1], mx_reg} + (MW+1)'(rx_neg);
            numv = {mp, 16'h0000} - $signed({{(MW-5){1'b0}}, pos_x_reg});
            dden = rx_reg;
        end
        numv_mag = numv[MW+16] ? (MW+17)'(-numv) : (MW+17)'(numv);
        dden_mag = dden[RW-1] ? RW'(-dden) : RW'(dden);
    end

    // texture u along the wall: low 16 bits of pos + dist*ray (other axis)
    assign wall_q   = mul_p_reg[31:16];
    assign wall_neg = side_reg ? rx_neg : ry_neg;
    assign wall_p   = side_reg ? pos_x_reg[15:0] : pos_y_reg[15:0];

    assign dm      = (32'(dist_reg) < 32'(SFULL)) ? 32'(dist_reg) : 32'(SFULL);
    assign shade_x = 32'(SFULL) - dm;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MRX:   begin mul_a = 24'(plane_x_mag); mul_b = 33'(cam_mag_reg); end
            S_MRY:   begin mul_a = 24'(plane_y_mag); mul_b = 33'(cam_mag_reg); end
            S_SDX:   begin mul_a = 24'(gap_x);       mul_b = ddx_reg;         end
            S_SDY:   begin mul_a = 24'(gap_y);       mul_b = ddy_reg;         end
            S_WALL:  begin
                mul_a = dist_reg;
                mul_b = side_reg ? 33'(rx_mag) : 33'(ry_mag);
            end
            // shade * 256 / span as (shade >> 8) * reciprocal >> 24
            S_BRI:   begin mul_a = 24'(shade_x[31:8]); mul_b = 33'(BRI_M);    end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            S_CAM: begin
                div_req.start = 1'b1;
                div_req.num   = NW'({cnum_mag, 16'h0000});
                div_req.den   = DW'(w_eff);
            end
            S_DDX: begin
                div_req.start = rx_nz;
                div_req.num   = NW'(33'h1_0000_0000);
                div_req.den   = DW'(rx_mag);
            end
            S_DDY: begin
                div_req.start = ry_nz;
                div_req.num   = NW'(33'h1_0000_0000);
                div_req.den   = DW'(ry_mag);
            end
            S_DIST: begin
                div_req.start = (dden != '0)
                             && !((numv != '0) && (numv[MW+16] != dden[RW-1]));
                div_req.num   = NW'({numv_mag, 16'h0000});
                div_req.den   = DW'(dden_mag);
            end
            S_LH: begin
                div_req.start = (dist_reg != '0);
                div_req.num   = NW'({h_eff, 16'h0000});
                div_req.den   = DW'(dist_reg);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // stripe limits
    assign half_h  = h_eff[9:1];
    assign half_lh = lh_reg[25:1];
    assign start_s = $signed({18'b0, half_h}) - $signed({2'b00, half_lh});
    assign end_s   = {18'b0, half_h} + {2'b00, half_lh};
    assign start_c = start_s[26] ? 10'd0 : start_s[9:0];
    assign end_c   = (end_s > 27'(h_eff - 10'd1)) ? (h_eff - 10'd1) : end_s[9:0];

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_addr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  begin
                if (s_valid && s_data.command == gdr_pkg::CMD_CAST) state_next = S_CAM;
            end
            S_CAM:   state_next = S_CAMW;
            S_CAMW:  if (div_rsp.done) state_next = S_MRX;
            S_MRX:   state_next = S_MRY;
            S_MRY:   state_next = S_RY;
            S_RY:    state_next = S_DDX;
            S_DDX:   state_next = rx_nz ? S_DDXW : S_DDY;
            S_DDXW:  if (div_rsp.done) state_next = S_DDY;
            S_DDY:   state_next = ry_nz ? S_DDYW : S_SDX;
            S_DDYW:  if (div_rsp.done) state_next = S_SDX;
            S_SDX:   state_next = S_SDY;
            S_SDY:   state_next = S_SDYW;
            S_SDYW:  state_next = S_STEP;
            S_STEP:  state_next = S_LOOK;
            S_LOOK:  begin
                if ((inb_reg && ram_rdata != 3'd0) || steps_reg == STW'(MAX_STEPS)) begin
                    state_next = S_DIST;
                end else begin
                    state_next = S_STEP;
                end
            end
            S_DIST:  state_next = div_req.start ? S_DISTW : S_WALL;
            S_DISTW: if (div_rsp.done) state_next = S_WALL;
            S_WALL:  state_next = S_WALLW;
            S_WALLW: state_next = S_LH;
            S_LH:    state_next = div_req.start ? S_LHW : S_BRI;
            S_LHW:   if (div_rsp.done) state_next = S_BRI;
            S_BRI:   state_next = S_BRIW;
            S_BRIW:  state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            steps_reg    <= '0;
            pos_x_reg    <= 21'd1441792;
            pos_y_reg    <= 21'd786432;
            dir_x_reg    <= -18'sd65536;
            dir_y_reg    <= 18'sd0;
            plane_x_reg  <= 18'sd0;
            plane_y_reg  <= 18'sd49152;
            width_reg    <= 10'd320;
            height_reg   <= 10'd200;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    gdr_pkg::REG_POS_X:    pos_x_reg   <= cfg_data;
                    gdr_pkg::REG_POS_Y:    pos_y_reg   <= cfg_data;
                    gdr_pkg::REG_DIR_X:    dir_x_reg   <= cfg_data[17:0];
                    gdr_pkg::REG_DIR_Y:    dir_y_reg   <= cfg_data[17:0];
                    gdr_pkg::REG_PLANE_X:  plane_x_reg <= cfg_data[17:0];
                    gdr_pkg::REG_PLANE_Y:  plane_y_reg <= cfg_data[17:0];
                    gdr_pkg::REG_SCREEN_W: width_reg   <= cfg_data[9:0];
                    gdr_pkg::REG_SCREEN_H: height_reg  <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (state_reg == S_CAM) begin
                steps_reg <= '0;
            end else if (state_reg == S_STEP) begin
                steps_reg <= steps_reg + STW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        mul_p_reg <= {33'b0, mul_a} * {24'b0, mul_b};

        if (s_valid && s_ready) begin
            column_reg <= s_data.column;
        end

        unique case (state_reg)
            S_CAM: begin
                mx_reg  <= MW'(pos_x_reg[20:16]);
                my_reg  <= MW'(pos_y_reg[20:16]);
                hit_reg <= 1'b0;
                side_reg <= 1'b0;
            end
            S_CAMW: begin
                cam_mag_reg <= div_rsp.quo[26:0];
                cam_neg_reg <= cnum[11];
            end
            S_MRY:  rx_reg <= dir_ext + prod_term;
            S_RY:   ry_reg <= dir_ext + prod_term;
            S_DDX:  if (!rx_nz) ddx_reg <= '0;
            S_DDXW: ddx_reg <= div_rsp.quo[32:0];
            S_DDY:  if (!ry_nz) ddy_reg <= '0;
            S_DDYW: ddy_reg <= div_rsp.quo[32:0];
            S_SDY:  sdx_reg <= SW'(mul_p_reg[56:16]);
            S_SDYW: sdy_reg <= SW'(mul_p_reg[56:16]);
            S_STEP: begin
                if (step_x) begin
                    sdx_reg <= sdx_reg + SW'(ddx_reg);
                end else begin
                    sdy_reg <= sdy_reg + SW'(ddy_reg);
                end
                side_reg <= !step_x;
                mx_reg   <= nmx;
                my_reg   <= nmy;
                inb_reg  <= n_inb;
            end
            S_LOOK: begin
                tile_reg <= inb_reg ? ram_rdata : 3'd0;
                hit_reg  <= inb_reg && (ram_rdata != 3'd0);
            end
            S_DIST: begin
                if (dden == '0) begin
                    dist_reg <= 24'hFF_FFFF;
                end else if (!div_req.start) begin
                    dist_reg <= '0;
                end
            end
            S_DISTW: begin
                dist_reg <= (div_rsp.quo[NW-1:24] != '0) ? 24'hFF_FFFF : div_rsp.quo[23:0];
            end
            S_WALLW: wall_u_reg <= wall_p + (wall_neg ? 16'(-wall_q) : wall_q);
            S_LH:    if (dist_reg == '0) lh_reg <= {h_eff, 16'h0000};
            S_LHW:   lh_reg <= div_rsp.quo[25:0];
            S_BRIW:  begin
                bright_reg <= (mul_p_reg[56:32] != '0) ? 8'hFF : mul_p_reg[31:24];
            end
            default: ;
        endcase

        if (out_load) begin
            m_data_reg.column_out    <= column_reg;
            m_data_reg.hit           <= hit_reg;
            m_data_reg.side          <= side_reg;
            m_data_reg.hit_x         <= mx_reg[4:0];
            m_data_reg.hit_y         <= my_reg[4:0];
            m_data_reg.texture_index <= hit_reg ? tile_reg - 3'd1 : 3'd0;
            m_data_reg.distance      <= dist_reg;
            m_data_reg.stripe_start  <= start_c;
            m_data_reg.stripe_end    <= end_c;
            m_data_reg.wall_u        <= wall_u_reg;
            m_data_reg.brightness    <= bright_reg;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ---------------- checks ----------------
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= STW'(MAX_STEPS))
        else $error("walk step count past limit");

    a_look_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOK) |-> $past(state_reg) == S_STEP)
        else $error("map read data sampled out of step");

    a_stripe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_data_reg.stripe_start <= m_data_reg.stripe_end)
        else $error("stripe start past stripe end");

endmodule

// File: design/gdr_ram.sv
// ---------------------------------------------------------------------------
// gdr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module gdr_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/gdr_div.sv
// ---------------------------------------------------------------------------
// gdr_div
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gdr_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gdr_pkg::gdr_div_req_t req,
    output gdr_pkg::gdr_div_rsp_t rsp
);

    localparam int NW = gdr_pkg::NUM_W;
    localparam int DW = gdr_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DW+1]) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// File: dv/grid_dda_wall_raycast_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_dda_wall_raycast_tb
// Self-checking bench for the DDA wall ray caster. A directed table covers
// field extremes, zero rays, zero screen size and a hand-checked hit. Random
// map loads and column casts follow over several camera settings. Input and
// output traffic is throttled in phases. Every result beat is compared field
// by field with an in-bench model of the cast, or with a typed hand value.
// ---------------------------------------------------------------------------
module grid_dda_wall_raycast_tb;

    localparam int MAPN = 32;
    localparam int STEP_LIMIT = 50;
    localparam int SHADE = 15;
    localparam longint DIST_SAT = 16777215;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    gdr_pkg::gdr_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    gdr_pkg::gdr_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gdr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    grid_dda_wall_raycast DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // camera state and map mirror
    logic [20:0] cam_pos_x, cam_pos_y;
    logic [17:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
    logic [9:0]  scr_w, scr_h;
    logic [2:0]  tiles [0:MAPN*MAPN-1];

    gdr_pkg::gdr_out_t pending_cols[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    typedef struct {
        bit                            is_cfg;
        logic [gdr_pkg::CFG_IDX_W-1:0] idx;
        logic [20:0]                   val;
        gdr_pkg::gdr_in_t              item;
        bit                            has_exp;
        gdr_pkg::gdr_out_t             exp;
    } row_t;
    row_t rows[$];

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("grid_dda_wall_raycast_tb: FAIL");
        $finish;
    end

    task automatic report(string what, longint got, longint want);
        errors++;
        if (errors <= 40)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    function automatic longint sx18(logic [17:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint mulq(longint a, longint b);
        longint r;
        r = longint'((absv(a) * absv(b)) >> 16);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [2:0] tile_at(longint x, longint y);
        if (x < 0 || y < 0 || x >= MAPN || y >= MAPN) return 3'd0;
        return tiles[x * MAPN + y];
    endfunction

    function automatic gdr_pkg::gdr_out_t cast_ray(logic [9:0] col);
        gdr_pkg::gdr_out_t r;
        longint w, h, px, py, cnum, cam, rx, ry, mx, my, num, den, lh, top, bot, wall;
        longint unsigned fx, fy, ddx, ddy, sdx, sdy, pdist, sfull, dm, shade;
        longint sxs, sys;
        bit hit, side;
        int steps;
        w = scr_w ? longint'(scr_w) : 1;
        h = scr_h ? longint'(scr_h) : 1;
        px = longint'(cam_pos_x);
        py = longint'(cam_pos_y);
        cnum = 2 * longint'(col) - w;
        cam = longint'((absv(cnum) << 16) / longint'(w));
        if (cnum < 0) cam = -cam;
        rx = sx18(cam_dir_x) + mulq(sx18(cam_plane_x), cam);
        ry = sx18(cam_dir_y) + mulq(sx18(cam_plane_y), cam);
        mx = px >>> 16;
        my = py >>> 16;
        fx = px & 'hFFFF;
        fy = py & 'hFFFF;
        ddx = rx != 0 ? (64'd1 << 32) / absv(rx) : 0;
        ddy = ry != 0 ? (64'd1 << 32) / absv(ry) : 0;
        sxs = rx < 0 ? -1 : 1;
        sys = ry < 0 ? -1 : 1;
        sdx = ((rx < 0 ? fx : 65536 - fx) * ddx) >> 16;
        sdy = ((ry < 0 ? fy : 65536 - fy) * ddy) >> 16;
        hit = 0;
        side = 0;
        steps = 0;
        while (!hit && steps < STEP_LIMIT) begin
            // zero x component never steps x; a fully zero ray walks y
            if (rx != 0 && (ry == 0 || sdx < sdy)) begin
                sdx += ddx; mx += sxs; side = 0;
            end else begin
                sdy += ddy; my += sys; side = 1;
            end
            steps++;
            if (tile_at(mx, my) != 0) hit = 1;
        end
        if (side == 0) begin
            num = (mx + (sxs < 0 ? 1 : 0)) * 65536 - px; den = rx;
        end else begin
            num = (my + (sys < 0 ? 1 : 0)) * 65536 - py; den = ry;
        end
        if (den == 0) pdist = DIST_SAT;
        else if (num != 0 && ((num < 0) != (den < 0))) pdist = 0;
        else begin
            pdist = (absv(num) << 16) / absv(den);
            if (pdist > DIST_SAT) pdist = DIST_SAT;
        end
        lh = pdist != 0 ? longint'((longint'(h) << 16) / pdist) : (h << 16);
        top = h / 2 - lh / 2;
        bot = h / 2 + lh / 2;
        if (top < 0) top = 0;
        if (bot > h - 1) bot = h - 1;
        wall = side == 0 ? py + mulq(longint'(pdist), ry) : px + mulq(longint'(pdist), rx);
        sfull = longint'(SHADE) << 16;
        dm = pdist < sfull ? pdist : sfull;
        shade = ((sfull - dm) * 256) / sfull;
        if (shade > 255) shade = 255;
        r.column_out = col;
        r.hit = hit;
        r.side = side;
        r.hit_x = mx[4:0];
        r.hit_y = my[4:0];
        r.texture_index = hit ? tile_at(mx, my) - 3'd1 : 3'd0;
        r.distance = pdist[23:0];
        r.stripe_start = top[9:0];
        r.stripe_end = bot[9:0];
        r.wall_u = wall[15:0];
        r.brightness = shade[7:0];
        return r;
    endfunction

    // result side: check every beat, throttle ready
    initial begin
        gdr_pkg::gdr_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_cols.size() == 0) begin
                    report("unexpected beat", m_data.column_out, 0);
                end else begin
                    want = pending_cols.pop_front();
                    if (m_data.column_out != want.column_out)
                        report("column_out", m_data.column_out, want.column_out);
                    if (m_data.hit != want.hit) report("hit", m_data.hit, want.hit);
                    if (m_data.side != want.side) report("side", m_data.side, want.side);
                    if (m_data.hit_x != want.hit_x) report("hit_x", m_data.hit_x, want.hit_x);
                    if (m_data.hit_y != want.hit_y) report("hit_y", m_data.hit_y, want.hit_y);
                    if (m_data.texture_index != want.texture_index)
                        report("texture_index", m_data.texture_index, want.texture_index);
                    if (m_data.distance != want.distance)
                        report("distance", m_data.distance, want.distance);
                    if (m_data.stripe_start != want.stripe_start)
                        report("stripe_start", m_data.stripe_start, want.stripe_start);
                    if (m_data.stripe_end != want.stripe_end)
                        report("stripe_end", m_data.stripe_end, want.stripe_end);
                    if (m_data.wall_u != want.wall_u)
                        report("wall_u", m_data.wall_u, want.wall_u);
                    if (m_data.brightness != want.brightness)
                        report("brightness", m_data.brightness, want.brightness);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic drain();
        while (pending_cols.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [gdr_pkg::CFG_IDX_W-1:0] idx, logic [20:0] val);
        s_valid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            gdr_pkg::REG_POS_X:    cam_pos_x = val;
            gdr_pkg::REG_POS_Y:    cam_pos_y = val;
            gdr_pkg::REG_DIR_X:    cam_dir_x = val[17:0];
            gdr_pkg::REG_DIR_Y:    cam_dir_y = val[17:0];
            gdr_pkg::REG_PLANE_X:  cam_plane_x = val[17:0];
            gdr_pkg::REG_PLANE_Y:  cam_plane_y = val[17:0];
            gdr_pkg::REG_SCREEN_W: scr_w = val[9:0];
            default:               scr_h = val[9:0];
        endcase
    endtask

    // offer one beat; on acceptance update the map or queue the expected column
    task automatic send(gdr_pkg::gdr_in_t it, bit typed, gdr_pkg::gdr_out_t typed_exp);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.command == gdr_pkg::CMD_WRITE)
            tiles[it.cell_x * MAPN + it.cell_y] = it.cell_value;
        else
            pending_cols.push_back(typed ? typed_exp : cast_ray(it.column));
    endtask

    task automatic add_cfg(logic [gdr_pkg::CFG_IDX_W-1:0] idx, logic [20:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1;
        r.idx = idx;
        r.val = val;
        rows.push_back(r);
    endtask

    task automatic add_item(logic cmd, logic [9:0] col, logic [4:0] cx, logic [4:0] cy,
                            logic [2:0] v);
        row_t r;
        r = '{default: '0};
        r.item = '{command: cmd, column: col, cell_x: cx, cell_y: cy, cell_value: v};
        rows.push_back(r);
    endtask

    function automatic gdr_pkg::gdr_in_t rand_item();
        gdr_pkg::gdr_in_t it;
        it.command = ($urandom_range(99) < 35) ? gdr_pkg::CMD_WRITE : gdr_pkg::CMD_CAST;
        it.column = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(scr_w));
        it.cell_x = 5'($urandom);
        it.cell_y = 5'($urandom);
        it.cell_value = ($urandom_range(1) == 0) ? 3'd0 : 3'($urandom);
        return it;
    endfunction

    task automatic rand_camera(bit extreme);
        write_reg(gdr_pkg::REG_POS_X, extreme ? 21'h1FFFFF : 21'($urandom));
        write_reg(gdr_pkg::REG_POS_Y, extreme ? 21'd0 : 21'($urandom));
        write_reg(gdr_pkg::REG_DIR_X, extreme ? 21'h20000 : 21'($urandom));
        write_reg(gdr_pkg::REG_DIR_Y, extreme ? 21'h1FFFF : 21'($urandom));
        write_reg(gdr_pkg::REG_PLANE_X, 21'($urandom));
        write_reg(gdr_pkg::REG_PLANE_Y, 21'($urandom));
        write_reg(gdr_pkg::REG_SCREEN_W, extreme ? 21'd1023 : 21'($urandom_range(1, 1023)));
        write_reg(gdr_pkg::REG_SCREEN_H, extreme ? 21'd1023 : 21'($urandom_range(1, 1023)));
    endtask

    task automatic rand_burst(int n);
        gdr_pkg::gdr_out_t none;
        none = '0;
        repeat (n) send(rand_item(), 0, none);
    endtask

    initial begin
        gdr_pkg::gdr_out_t hand;
        int waited;
        cam_pos_x = 21'd1441792; cam_pos_y = 21'd786432;
        cam_dir_x = 18'h30000;   cam_dir_y = '0;
        cam_plane_x = '0;        cam_plane_y = 18'd49152;
        scr_w = 10'd320;         scr_h = 10'd200;
        foreach (tiles[i]) tiles[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset camera over an empty map: misses at column 0 and past the right edge
        add_item(gdr_pkg::CMD_CAST, 10'd0, 5'd0, 5'd0, 3'd0);
        add_item(gdr_pkg::CMD_CAST, 10'd1023, 5'd31, 5'd31, 3'd7);
        // straight +x ray from (1.5,1.5) into a wall half a cell away
        add_cfg(gdr_pkg::REG_POS_X, 21'd98304);
        add_cfg(gdr_pkg::REG_POS_Y, 21'd98304);
        add_cfg(gdr_pkg::REG_DIR_X, 21'd65536);
        add_cfg(gdr_pkg::REG_DIR_Y, 21'd0);
        add_cfg(gdr_pkg::REG_PLANE_X, 21'd0);
        add_cfg(gdr_pkg::REG_PLANE_Y, 21'd0);
        add_item(gdr_pkg::CMD_WRITE, 10'd0, 5'd2, 5'd1, 3'd5);
        add_item(gdr_pkg::CMD_CAST, 10'd7, 5'd0, 5'd0, 3'd0);
        rows[$].has_exp = 1;
        hand = '0;
        hand.column_out = 10'd7; hand.hit = 1; hand.side = 0;
        hand.hit_x = 5'd2; hand.hit_y = 5'd1; hand.texture_index = 3'd4;
        hand.distance = 24'd32768; hand.stripe_start = 10'd0; hand.stripe_end = 10'd199;
        hand.wall_u = 16'd32768; hand.brightness = 8'd247;
        rows[$].exp = hand;
        // corner tiles and a cleared cell
        add_item(gdr_pkg::CMD_WRITE, 10'd1023, 5'd0, 5'd0, 3'd7);
        add_item(gdr_pkg::CMD_WRITE, 10'd0, 5'd31, 5'd31, 3'd1);
        add_item(gdr_pkg::CMD_WRITE, 10'd0, 5'd2, 5'd1, 3'd0);
        add_item(gdr_pkg::CMD_CAST, 10'd512, 5'd0, 5'd0, 3'd0);
        // zero ray walks y only; zero screen size acts as one
        add_cfg(gdr_pkg::REG_DIR_X, 21'd0);
        add_cfg(gdr_pkg::REG_SCREEN_W, 21'd0);
        add_cfg(gdr_pkg::REG_SCREEN_H, 21'd0);
        add_item(gdr_pkg::CMD_CAST, 10'd0, 5'd0, 5'd0, 3'd0);
        add_item(gdr_pkg::CMD_CAST, 10'd1023, 5'd0, 5'd0, 3'd0);
        // walk off the far map edge, then off the near edge from the origin corner
        add_cfg(gdr_pkg::REG_POS_X, 21'h1FFFFF);
        add_cfg(gdr_pkg::REG_POS_Y, 21'h1FFFFF);
        add_cfg(gdr_pkg::REG_DIR_X, 21'h1FFFF);
        add_cfg(gdr_pkg::REG_PLANE_Y, 21'h20000);
        add_cfg(gdr_pkg::REG_SCREEN_W, 21'd1);
        add_cfg(gdr_pkg::REG_SCREEN_H, 21'd1023);
        add_item(gdr_pkg::CMD_CAST, 10'd0, 5'd0, 5'd0, 3'd0);
        add_item(gdr_pkg::CMD_CAST, 10'd1, 5'd0, 5'd0, 3'd0);
        add_cfg(gdr_pkg::REG_POS_X, 21'd0);
        add_cfg(gdr_pkg::REG_POS_Y, 21'd0);
        add_cfg(gdr_pkg::REG_DIR_X, 21'h20000);
        add_cfg(gdr_pkg::REG_DIR_Y, 21'h20000);
        add_item(gdr_pkg::CMD_CAST, 10'd1023, 5'd0, 5'd0, 3'd0);
        add_item(gdr_pkg::CMD_CAST, 10'd0, 5'd0, 5'd0, 3'd0);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
            else send(rows[i].item, rows[i].has_exp, rows[i].exp);
        end

        // random phases: idle mix, camera, then beats
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            rand_camera(ph == 4);
            if (ph == 0) begin
                // long output hold-off while inputs keep coming
                hold_left = 3000;
                rand_burst(40);
            end
            rand_burst(205);
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending_cols.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (600) @(posedge aclk);
        if (errors == 0 && pending_cols.size() == 0)
            $display("grid_dda_wall_raycast_tb: PASS");
        else
            $display("grid_dda_wall_raycast_tb: FAIL");
        $finish;
    end
endmodule
